### rtl/pfe_pkg.sv
// ----------------------------------------------------------------------------
// pfe_pkg: palette fade engine shared definitions
// Sizes, mode and operation codes, command word layout and channel helpers.
// ----------------------------------------------------------------------------
package pfe_pkg;

    localparam int PALETTE_ENTRIES = 64;
    localparam int CHANNEL_BITS    = 6;
    localparam int FIELD_BITS      = 6;
    localparam int MODE_BITS       = 3;
    localparam int ENTRY_BITS      = $clog2(PALETTE_ENTRIES);
    localparam int RGB_BITS        = 3 * CHANNEL_BITS;
    localparam int OP_BITS         = 3;
    localparam int QUEUE_DEPTH     = 2;
    localparam int QPTR_BITS       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS       = $clog2(QUEUE_DEPTH + 1);
    localparam int WRAP_STEPS      = 4;

    localparam logic [MODE_BITS-1:0] MODE_WR_CUR  = 3'd0;
    localparam logic [MODE_BITS-1:0] MODE_WR_TGT  = 3'd1;
    localparam logic [MODE_BITS-1:0] MODE_RD_REG  = 3'd2;
    localparam logic [MODE_BITS-1:0] MODE_RD_ATTR = 3'd3;
    localparam logic [MODE_BITS-1:0] MODE_MORPH   = 3'd4;
    localparam logic [MODE_BITS-1:0] MODE_COPY    = 3'd5;

    localparam logic [OP_BITS-1:0] OP_WR_CUR = 3'd0;
    localparam logic [OP_BITS-1:0] OP_WR_TGT = 3'd1;
    localparam logic [OP_BITS-1:0] OP_READ   = 3'd2;
    localparam logic [OP_BITS-1:0] OP_MORPH  = 3'd3;
    localparam logic [OP_BITS-1:0] OP_COPY   = 3'd4;
    localparam logic [OP_BITS-1:0] OP_NOP    = 3'd5;

    typedef logic [CHANNEL_BITS-1:0] chan_t;
    typedef logic [ENTRY_BITS-1:0]   entry_t;
    typedef logic [FIELD_BITS-1:0]   field_t;

    localparam entry_t LAST_ENTRY = entry_t'(PALETTE_ENTRIES - 1);

    typedef struct packed {
        chan_t red;
        chan_t green;
        chan_t blue;
    } rgb_t;

    typedef struct packed {
        logic [OP_BITS-1:0] op;
        entry_t             entry;
        rgb_t               rgb;
    } cmd_t;

    function automatic field_t attr_entry(input logic [3:0] attr);
        field_t r;
        case (attr)
            4'd0:    r = 6'd0;
            4'd1:    r = 6'd1;
            4'd2:    r = 6'd2;
            4'd3:    r = 6'd3;
            4'd4:    r = 6'd4;
            4'd5:    r = 6'd5;
            4'd6:    r = 6'd20;
            4'd7:    r = 6'd7;
            4'd8:    r = 6'd56;
            4'd9:    r = 6'd57;
            4'd10:   r = 6'd58;
            4'd11:   r = 6'd59;
            4'd12:   r = 6'd60;
            4'd13:   r = 6'd61;
            4'd14:   r = 6'd62;
            default: r = 6'd63;
        endcase
        return r;
    endfunction

    function automatic entry_t wrap_entry(input field_t v);
        logic [31:0] t;
        t = 32'(v);
        for (int k = 0; k < WRAP_STEPS; k++)
        begin
            if (t >= 32'(PALETTE_ENTRIES))
            begin
                t = t - 32'(PALETTE_ENTRIES);
            end
        end
        return t[ENTRY_BITS-1:0];
    endfunction

    function automatic chan_t field_to_chan(input field_t f);
        logic [31:0] t;
        t = 32'(f);
        return t[CHANNEL_BITS-1:0];
    endfunction

    function automatic field_t chan_to_field(input chan_t c);
        logic [31:0] t;
        t = 32'(c);
        return t[FIELD_BITS-1:0];
    endfunction

    function automatic field_t entry_to_field(input entry_t e);
        logic [31:0] t;
        t = 32'(e);
        return t[FIELD_BITS-1:0];
    endfunction

    function automatic chan_t approach(input chan_t c, input chan_t t);
        chan_t r;
        if (c > t)
        begin
            r = c - chan_t'(1);
        end
        else if (c < t)
        begin
            r = c + chan_t'(1);
        end
        else
        begin
            r = c;
        end
        return r;
    endfunction

endpackage

### rtl/pfe_ram.sv
// ----------------------------------------------------------------------------
// pfe_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pfe_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/pfe_front.sv
// ----------------------------------------------------------------------------
// pfe_front: command intake and queue
// Accepts words, maps modes to operations, resolves the addressed entry
// and holds decoded commands in a short queue for the back end.
// ----------------------------------------------------------------------------
module pfe_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [pfe_pkg::MODE_BITS-1:0]     mode,
    input  logic [pfe_pkg::FIELD_BITS-1:0]    index,
    input  logic [pfe_pkg::FIELD_BITS-1:0]    red_in,
    input  logic [pfe_pkg::FIELD_BITS-1:0]    green_in,
    input  logic [pfe_pkg::FIELD_BITS-1:0]    blue_in,
    input  logic                              pop,
    output logic                              cmd_valid,
    output pfe_pkg::cmd_t                     cmd
);

    pfe_pkg::cmd_t                   cmd_in;
    pfe_pkg::cmd_t                   q_reg [pfe_pkg::QUEUE_DEPTH];
    logic [pfe_pkg::QPTR_BITS-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [pfe_pkg::QPTR_BITS-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [pfe_pkg::QCNT_BITS-1:0]   count_reg, count_next;
    logic                            push;

    always_comb
    begin
        case (mode)
            pfe_pkg::MODE_WR_CUR:  cmd_in.op = pfe_pkg::OP_WR_CUR;
            pfe_pkg::MODE_WR_TGT:  cmd_in.op = pfe_pkg::OP_WR_TGT;
            pfe_pkg::MODE_RD_REG:  cmd_in.op = pfe_pkg::OP_READ;
            pfe_pkg::MODE_RD_ATTR: cmd_in.op = pfe_pkg::OP_READ;
            pfe_pkg::MODE_MORPH:   cmd_in.op = pfe_pkg::OP_MORPH;
            pfe_pkg::MODE_COPY:    cmd_in.op = pfe_pkg::OP_COPY;
            default:               cmd_in.op = pfe_pkg::OP_NOP;
        endcase
        if (mode == pfe_pkg::MODE_RD_ATTR)
        begin
            cmd_in.entry = pfe_pkg::wrap_entry(pfe_pkg::attr_entry(index[3:0]));
        end
        else
        begin
            cmd_in.entry = pfe_pkg::wrap_entry(index);
        end
        cmd_in.rgb.red   = pfe_pkg::field_to_chan(red_in);
        cmd_in.rgb.green = pfe_pkg::field_to_chan(green_in);
        cmd_in.rgb.blue  = pfe_pkg::field_to_chan(blue_in);
    end

    assign busy      = (count_reg == pfe_pkg::QCNT_BITS'(pfe_pkg::QUEUE_DEPTH));
    assign cmd_valid = (count_reg != '0);
    assign cmd       = q_reg[rd_ptr_reg];
    assign push      = start && !busy;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + pfe_pkg::QPTR_BITS'(1);
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + pfe_pkg::QPTR_BITS'(1);
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + pfe_pkg::QCNT_BITS'(1);
            2'b01:   count_next = count_reg - pfe_pkg::QCNT_BITS'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

### rtl/pfe_back.sv
// ----------------------------------------------------------------------------
// pfe_back: palette storage and command execution
// Holds both palettes in RAM with per-entry valid bits, performs writes
// and reads, sweeps all entries for morph and copy, and drives results.
// ----------------------------------------------------------------------------
module pfe_back (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cmd_valid,
    input  pfe_pkg::cmd_t                     cmd,
    output logic                              pop,
    output logic                              done,
    output logic [pfe_pkg::FIELD_BITS-1:0]    red_out,
    output logic [pfe_pkg::FIELD_BITS-1:0]    green_out,
    output logic [pfe_pkg::FIELD_BITS-1:0]    blue_out,
    output logic [pfe_pkg::FIELD_BITS-1:0]    entry_used
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_READ  = 2'd1;
    localparam logic [1:0] ST_SWEEP = 2'd2;
    localparam logic [1:0] ST_DRAIN = 2'd3;

    logic [1:0]                            state_reg, state_next;
    pfe_pkg::entry_t                       cnt_reg, cnt_next;
    pfe_pkg::entry_t                       entry_reg, entry_next;
    pfe_pkg::entry_t                       paddr_reg, paddr_next;
    logic [pfe_pkg::OP_BITS-1:0]           op_reg, op_next;
    logic                                  pend_reg, pend_next;
    logic                                  cvld_reg, cvld_next;
    logic                                  tvld_reg, tvld_next;
    logic [pfe_pkg::PALETTE_ENTRIES-1:0]   cur_vld_reg, cur_vld_next;
    logic [pfe_pkg::PALETTE_ENTRIES-1:0]   tgt_vld_reg, tgt_vld_next;
    logic                                  done_reg, done_next;
    pfe_pkg::field_t                       red_reg, red_next;
    pfe_pkg::field_t                       green_reg, green_next;
    pfe_pkg::field_t                       blue_reg, blue_next;
    pfe_pkg::field_t                       used_reg, used_next;

    logic                                  cur_we, tgt_we;
    pfe_pkg::entry_t                       cur_waddr, cur_raddr;
    pfe_pkg::rgb_t                         cur_wdata;
    logic [pfe_pkg::RGB_BITS-1:0]          cur_rdata, tgt_rdata;
    pfe_pkg::rgb_t                         cur_eff, tgt_eff, sweep_rgb;

    pfe_ram #(
        .WIDTH (pfe_pkg::RGB_BITS),
        .DEPTH (pfe_pkg::PALETTE_ENTRIES)
    ) u_cur_ram (
        .clk   (clk),
        .we    (cur_we),
        .waddr (cur_waddr),
        .wdata (cur_wdata),
        .raddr (cur_raddr),
        .rdata (cur_rdata)
    );

    pfe_ram #(
        .WIDTH (pfe_pkg::RGB_BITS),
        .DEPTH (pfe_pkg::PALETTE_ENTRIES)
    ) u_tgt_ram (
        .clk   (clk),
        .we    (tgt_we),
        .waddr (cmd.entry),
        .wdata (cmd.rgb),
        .raddr (cnt_reg),
        .rdata (tgt_rdata)
    );

    assign cur_eff = cvld_reg ? pfe_pkg::rgb_t'(cur_rdata) : '0;
    assign tgt_eff = tvld_reg ? pfe_pkg::rgb_t'(tgt_rdata) : '0;

    always_comb
    begin
        if (op_reg == pfe_pkg::OP_COPY)
        begin
            sweep_rgb = tgt_eff;
        end
        else
        begin
            sweep_rgb.red   = pfe_pkg::approach(cur_eff.red, tgt_eff.red);
            sweep_rgb.green = pfe_pkg::approach(cur_eff.green, tgt_eff.green);
            sweep_rgb.blue  = pfe_pkg::approach(cur_eff.blue, tgt_eff.blue);
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        entry_next   = entry_reg;
        paddr_next   = paddr_reg;
        op_next      = op_reg;
        pend_next    = 1'b0;
        cvld_next    = cvld_reg;
        tvld_next    = tvld_reg;
        cur_vld_next = cur_vld_reg;
        tgt_vld_next = tgt_vld_reg;
        done_next    = 1'b0;
        red_next     = red_reg;
        green_next   = green_reg;
        blue_next    = blue_reg;
        used_next    = used_reg;
        pop          = 1'b0;
        cur_we       = 1'b0;
        tgt_we       = 1'b0;
        cur_waddr    = cmd.entry;
        cur_wdata    = cmd.rgb;
        cur_raddr    = cnt_reg;

        // retire the entry whose read was issued in the previous sweep cycle
        if (pend_reg)
        begin
            cur_we                  = 1'b1;
            cur_waddr               = paddr_reg;
            cur_wdata               = sweep_rgb;
            cur_vld_next[paddr_reg] = 1'b1;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    pop = 1'b1;
                    case (cmd.op)
                        pfe_pkg::OP_WR_CUR:
                        begin
                            cur_we                  = 1'b1;
                            cur_vld_next[cmd.entry] = 1'b1;
                            done_next               = 1'b1;
                            red_next                = '0;
                            green_next              = '0;
                            blue_next               = '0;
                            used_next               = pfe_pkg::entry_to_field(cmd.entry);
                        end
                        pfe_pkg::OP_WR_TGT:
                        begin
                            tgt_we                  = 1'b1;
                            tgt_vld_next[cmd.entry] = 1'b1;
                            done_next               = 1'b1;
                            red_next                = '0;
                            green_next              = '0;
                            blue_next               = '0;
                            used_next               = pfe_pkg::entry_to_field(cmd.entry);
                        end
                        pfe_pkg::OP_READ:
                        begin
                            cur_raddr  = cmd.entry;
                            cvld_next  = cur_vld_reg[cmd.entry];
                            entry_next = cmd.entry;
                            state_next = ST_READ;
                        end
                        pfe_pkg::OP_MORPH,
                        pfe_pkg::OP_COPY:
                        begin
                            op_next    = cmd.op;
                            cnt_next   = '0;
                            state_next = ST_SWEEP;
                        end
                        default:
                        begin
                            done_next  = 1'b1;
                            red_next   = '0;
                            green_next = '0;
                            blue_next  = '0;
                            used_next  = '0;
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                done_next  = 1'b1;
                red_next   = pfe_pkg::chan_to_field(cur_eff.red);
                green_next = pfe_pkg::chan_to_field(cur_eff.green);
                blue_next  = pfe_pkg::chan_to_field(cur_eff.blue);
                used_next  = pfe_pkg::entry_to_field(entry_reg);
                state_next = ST_IDLE;
            end
            ST_SWEEP:
            begin
                pend_next  = 1'b1;
                paddr_next = cnt_reg;
                cvld_next  = cur_vld_reg[cnt_reg];
                tvld_next  = tgt_vld_reg[cnt_reg];
                if (cnt_reg == pfe_pkg::LAST_ENTRY)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    cnt_next = cnt_reg + pfe_pkg::entry_t'(1);
                end
            end
            ST_DRAIN:
            begin
                done_next  = 1'b1;
                red_next   = '0;
                green_next = '0;
                blue_next  = '0;
                used_next  = '0;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            op_reg      <= pfe_pkg::OP_NOP;
            pend_reg    <= 1'b0;
            cvld_reg    <= 1'b0;
            tvld_reg    <= 1'b0;
            cur_vld_reg <= '0;
            tgt_vld_reg <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            op_reg      <= op_next;
            pend_reg    <= pend_next;
            cvld_reg    <= cvld_next;
            tvld_reg    <= tvld_next;
            cur_vld_reg <= cur_vld_next;
            tgt_vld_reg <= tgt_vld_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        paddr_reg <= paddr_next;
        red_reg   <= red_next;
        green_reg <= green_next;
        blue_reg  <= blue_next;
        used_reg  <= used_next;
    end

    assign done       = done_reg;
    assign red_out    = red_reg;
    assign green_out  = green_reg;
    assign blue_out   = blue_reg;
    assign entry_used = used_reg;

endmodule

### rtl/palette_fade_engine_core.sv
// ----------------------------------------------------------------------------
// palette_fade_engine_core: palette fade engine top level
// done is registered: writes and unused modes raise it from the idle
// state, reads from ST_READ after the registered RAM read, and morph and
// copy from ST_DRAIN after one RAM pass. The back end takes a word only
// when idle; a two-word queue in front lets start be taken while a sweep
// runs. Reset clears both palettes at once through per-entry valid bits.
// ----------------------------------------------------------------------------
module palette_fade_engine_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [pfe_pkg::MODE_BITS-1:0]     mode,
    input  logic [pfe_pkg::FIELD_BITS-1:0]    index,
    input  logic [pfe_pkg::FIELD_BITS-1:0]    red_in,
    input  logic [pfe_pkg::FIELD_BITS-1:0]    green_in,
    input  logic [pfe_pkg::FIELD_BITS-1:0]    blue_in,
    output logic                              done,
    output logic [pfe_pkg::FIELD_BITS-1:0]    red_out,
    output logic [pfe_pkg::FIELD_BITS-1:0]    green_out,
    output logic [pfe_pkg::FIELD_BITS-1:0]    blue_out,
    output logic [pfe_pkg::FIELD_BITS-1:0]    entry_used
);

    logic          pop;
    logic          cmd_valid;
    pfe_pkg::cmd_t cmd;

    pfe_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .mode      (mode),
        .index     (index),
        .red_in    (red_in),
        .green_in  (green_in),
        .blue_in   (blue_in),
        .pop       (pop),
        .cmd_valid (cmd_valid),
        .cmd       (cmd)
    );

    pfe_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd        (cmd),
        .pop        (pop),
        .done       (done),
        .red_out    (red_out),
        .green_out  (green_out),
        .blue_out   (blue_out),
        .entry_used (entry_used)
    );

endmodule

### sim/palette_fade_engine_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// palette_fade_engine_core_test: self-checking palette fade engine testbench
// A directed table of words followed by fade sequences and random words
// drives the command port under several idle mixes. Results are compared
// with a shadow copy of both palettes or with fixed values from the table.
// ----------------------------------------------------------------------------
module palette_fade_engine_core_test;
    import pfe_pkg::*;

    localparam logic [MODE_BITS-1:0] MODE_SPARE_6 = 3'd6;
    localparam logic [MODE_BITS-1:0] MODE_SPARE_7 = 3'd7;
    localparam int RANDOM_WORDS = 750;
    localparam int DRAIN_EVERY  = 150;
    localparam int SWEEP_CYCLES = PALETTE_ENTRIES + 2;
    localparam int STALL_LIMIT  = 20 * SWEEP_CYCLES;
    localparam int TAIL_CYCLES  = 3 * SWEEP_CYCLES;
    localparam int DIRECTED_ROWS = 24;

    typedef struct packed {
        logic [MODE_BITS-1:0] mode;
        field_t               index;
        field_t               red;
        field_t               green;
        field_t               blue;
        logic                 fixed;
        field_t               red_x;
        field_t               green_x;
        field_t               blue_x;
        field_t               entry_x;
        logic                 drain;
        logic [6:0]           idle_pct;
    } fade_word_t;

    typedef struct packed {
        field_t red;
        field_t green;
        field_t blue;
        field_t entry;
    } fade_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    logic [MODE_BITS-1:0]  mode = '0;
    field_t                index = '0;
    field_t                red_in = '0;
    field_t                green_in = '0;
    field_t                blue_in = '0;
    logic                  done;
    field_t                red_out;
    field_t                green_out;
    field_t                blue_out;
    field_t                entry_used;

    rgb_t          cur_shadow [PALETTE_ENTRIES];
    rgb_t          tgt_shadow [PALETTE_ENTRIES];
    fade_word_t    fade_words [$];
    fade_result_t  results_due [$];
    fade_word_t    directed_rows [0:DIRECTED_ROWS-1];
    int            word_ptr = 0;
    int            errors = 0;
    int            stall_cycles = 0;
    int            rand_count = 0;
    int            drain_mark = 0;
    logic [6:0]    cur_idle = '0;

    palette_fade_engine_core u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .mode       (mode),
        .index      (index),
        .red_in     (red_in),
        .green_in   (green_in),
        .blue_in    (blue_in),
        .done       (done),
        .red_out    (red_out),
        .green_out  (green_out),
        .blue_out   (blue_out),
        .entry_used (entry_used)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic entry_t ega_register(input field_t attr);
        logic [3:0] a;
        entry_t     r;
        a = attr[3:0];
        if (a < 4'd6)
        begin
            r = entry_t'(a);
        end
        else if (a == 4'd6)
        begin
            r = entry_t'(20);
        end
        else if (a == 4'd7)
        begin
            r = entry_t'(7);
        end
        else
        begin
            r = entry_t'(48 + int'(a));
        end
        return r;
    endfunction

    function automatic chan_t step_toward(input chan_t c, input chan_t goal);
        chan_t r;
        r = c;
        if (c < goal)
        begin
            r = c + chan_t'(1);
        end
        else if (c > goal)
        begin
            r = c - chan_t'(1);
        end
        return r;
    endfunction

    task automatic predict_fade(input fade_word_t w, output fade_result_t r);
        entry_t e;
        r = '0;
        e = entry_t'(int'(w.index) % PALETTE_ENTRIES);
        case (w.mode)
            MODE_WR_CUR:
            begin
                cur_shadow[e] = {chan_t'(w.red), chan_t'(w.green), chan_t'(w.blue)};
                r.entry = field_t'(e);
            end
            MODE_WR_TGT:
            begin
                tgt_shadow[e] = {chan_t'(w.red), chan_t'(w.green), chan_t'(w.blue)};
                r.entry = field_t'(e);
            end
            MODE_RD_REG, MODE_RD_ATTR:
            begin
                if (w.mode == MODE_RD_ATTR)
                begin
                    e = entry_t'(int'(ega_register(w.index)) % PALETTE_ENTRIES);
                end
                r.red   = field_t'(cur_shadow[e].red);
                r.green = field_t'(cur_shadow[e].green);
                r.blue  = field_t'(cur_shadow[e].blue);
                r.entry = field_t'(e);
            end
            MODE_MORPH:
            begin
                for (int i = 0; i < PALETTE_ENTRIES; i++)
                begin
                    cur_shadow[i].red   = step_toward(cur_shadow[i].red, tgt_shadow[i].red);
                    cur_shadow[i].green = step_toward(cur_shadow[i].green,
                                                      tgt_shadow[i].green);
                    cur_shadow[i].blue  = step_toward(cur_shadow[i].blue, tgt_shadow[i].blue);
                end
            end
            MODE_COPY:
            begin
                for (int i = 0; i < PALETTE_ENTRIES; i++)
                begin
                    cur_shadow[i] = tgt_shadow[i];
                end
            end
            default:
            begin
            end
        endcase
    endtask

    function automatic fade_word_t dir_row(input logic [MODE_BITS-1:0] m, input field_t ix);
        fade_word_t w;
        w = '0;
        w.mode  = m;
        w.index = ix;
        return w;
    endfunction

    function automatic fade_word_t dir_fix(input logic [MODE_BITS-1:0] m, input field_t ix,
                                           input field_t r, input field_t g, input field_t b,
                                           input field_t xr, input field_t xg,
                                           input field_t xb, input field_t xe);
        fade_word_t w;
        w = '0;
        w.mode    = m;
        w.index   = ix;
        w.red     = r;
        w.green   = g;
        w.blue    = b;
        w.fixed   = 1'b1;
        w.red_x   = xr;
        w.green_x = xg;
        w.blue_x  = xb;
        w.entry_x = xe;
        return w;
    endfunction

    function automatic field_t rand_field();
        return field_t'($urandom_range(0, 63));
    endfunction

    function automatic field_t near_chan(input field_t c);
        int v;
        v = int'(c) + int'($urandom_range(0, 6)) - 3;
        if (v < 0)
        begin
            v = 0;
        end
        if (v > 63)
        begin
            v = 63;
        end
        return field_t'(v);
    endfunction

    task automatic push_word(input logic [MODE_BITS-1:0] m, input field_t ix,
                             input field_t r, input field_t g, input field_t b);
        fade_word_t w;
        w = '0;
        w.mode     = m;
        w.index    = ix;
        w.red      = r;
        w.green    = g;
        w.blue     = b;
        w.idle_pct = cur_idle;
        if (rand_count == drain_mark)
        begin
            w.drain    = 1'b1;
            drain_mark = drain_mark + DRAIN_EVERY;
        end
        fade_words.push_back(w);
        rand_count++;
    endtask

    task automatic build_stimulus();
        field_t e;
        field_t rr;
        field_t gg;
        field_t bb;
        int     pick;
        int     steps;
        directed_rows = '{
            dir_fix(MODE_RD_REG,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0),
            dir_fix(MODE_RD_REG,  6'd63, 6'd63, 6'd63, 6'd63, 6'd0,  6'd0,  6'd0,  6'd63),
            dir_fix(MODE_RD_ATTR, 6'd15, 6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd63),
            dir_fix(MODE_RD_ATTR, 6'd6,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd20),
            dir_fix(MODE_WR_CUR,  6'd0,  6'd63, 6'd63, 6'd63, 6'd0,  6'd0,  6'd0,  6'd0),
            dir_fix(MODE_WR_CUR,  6'd63, 6'd42, 6'd21, 6'd63, 6'd0,  6'd0,  6'd0,  6'd63),
            dir_fix(MODE_RD_REG,  6'd0,  6'd0,  6'd0,  6'd0,  6'd63, 6'd63, 6'd63, 6'd0),
            dir_fix(MODE_RD_ATTR, 6'd63, 6'd0,  6'd0,  6'd0,  6'd42, 6'd21, 6'd63, 6'd63),
            dir_fix(MODE_RD_ATTR, 6'd24, 6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd56),
            dir_fix(MODE_WR_TGT,  6'd0,  6'd62, 6'd0,  6'd63, 6'd0,  6'd0,  6'd0,  6'd0),
            dir_fix(MODE_WR_TGT,  6'd63, 6'd42, 6'd22, 6'd60, 6'd0,  6'd0,  6'd0,  6'd63),
            dir_fix(MODE_SPARE_6, 6'd63, 6'd63, 6'd63, 6'd63, 6'd0,  6'd0,  6'd0,  6'd0),
            dir_fix(MODE_SPARE_7, 6'd63, 6'd63, 6'd63, 6'd63, 6'd0,  6'd0,  6'd0,  6'd0),
            dir_fix(MODE_MORPH,   6'd63, 6'd63, 6'd63, 6'd63, 6'd0,  6'd0,  6'd0,  6'd0),
            dir_row(MODE_RD_REG,  6'd0),
            dir_row(MODE_RD_REG,  6'd63),
            dir_fix(MODE_MORPH,   6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0),
            dir_row(MODE_RD_REG,  6'd63),
            dir_fix(MODE_WR_TGT,  6'd20, 6'd10, 6'd20, 6'd30, 6'd0,  6'd0,  6'd0,  6'd20),
            dir_fix(MODE_COPY,    6'd45, 6'd1,  6'd2,  6'd3,  6'd0,  6'd0,  6'd0,  6'd0),
            dir_row(MODE_RD_ATTR, 6'd6),
            dir_row(MODE_RD_REG,  6'd63),
            dir_fix(MODE_MORPH,   6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0),
            dir_row(MODE_RD_ATTR, 6'd47)
        };
        for (int i = 0; i < DIRECTED_ROWS; i++)
        begin
            fade_words.push_back(directed_rows[i]);
        end
        while (rand_count < RANDOM_WORDS)
        begin
            case ((rand_count * 4) / RANDOM_WORDS)
                0:       cur_idle = 7'd0;
                1:       cur_idle = 7'd71;
                2:       cur_idle = 7'd0;
                default: cur_idle = 7'd32;
            endcase
            pick = $urandom_range(0, 99);
            if (pick < 35)
            begin
                // fade one entry toward a target, mostly a nearby one, and read it back
                e  = rand_field();
                rr = rand_field();
                gg = rand_field();
                bb = rand_field();
                push_word(MODE_WR_CUR, e, rr, gg, bb);
                if ($urandom_range(0, 3) == 0)
                begin
                    push_word(MODE_WR_TGT, e, rand_field(), rand_field(), rand_field());
                end
                else
                begin
                    push_word(MODE_WR_TGT, e, near_chan(rr), near_chan(gg), near_chan(bb));
                end
                steps = $urandom_range(1, 4);
                for (int k = 0; k < steps; k++)
                begin
                    push_word(MODE_MORPH, rand_field(), rand_field(), rand_field(),
                              rand_field());
                    if ($urandom_range(0, 1) == 1)
                    begin
                        push_word(MODE_RD_REG, e, rand_field(), rand_field(), rand_field());
                    end
                end
                push_word(MODE_RD_REG, e, rand_field(), rand_field(), rand_field());
                push_word(MODE_RD_ATTR, rand_field(), rand_field(), rand_field(),
                          rand_field());
            end
            else
            begin
                pick = $urandom_range(0, 99);
                push_word(pick < 25 ? MODE_WR_CUR :
                          pick < 45 ? MODE_WR_TGT :
                          pick < 65 ? MODE_RD_REG :
                          pick < 80 ? MODE_RD_ATTR :
                          pick < 88 ? MODE_MORPH :
                          pick < 93 ? MODE_COPY :
                          pick < 97 ? MODE_SPARE_6 : MODE_SPARE_7,
                          rand_field(), rand_field(), rand_field(), rand_field());
            end
        end
    endtask

    task automatic check_field(input string name, input field_t want, input field_t got);
        if (want !== got)
        begin
            $display("%0t mismatch %s expected %0d actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin : drive_and_check
        fade_word_t   nxt;
        fade_result_t want;
        logic         moved;
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else
        begin
            moved = 1'b0;
            if (done)
            begin
                moved = 1'b1;
                if (results_due.size() == 0)
                begin
                    $display("%0t unexpected word red %0d green %0d blue %0d entry %0d",
                             $time, red_out, green_out, blue_out, entry_used);
                    errors++;
                end
                else
                begin
                    want = results_due.pop_front();
                    check_field("red_out", want.red, red_out);
                    check_field("green_out", want.green, green_out);
                    check_field("blue_out", want.blue, blue_out);
                    check_field("entry_used", want.entry, entry_used);
                end
            end
            if (start && !busy)
            begin
                moved = 1'b1;
                nxt = fade_words[word_ptr];
                predict_fade(nxt, want);
                if (nxt.fixed)
                begin
                    want = {nxt.red_x, nxt.green_x, nxt.blue_x, nxt.entry_x};
                end
                results_due.push_back(want);
                word_ptr++;
            end
            if (!(start && busy))
            begin
                if (word_ptr < fade_words.size())
                begin
                    nxt = fade_words[word_ptr];
                    mode     <= nxt.mode;
                    index    <= nxt.index;
                    red_in   <= nxt.red;
                    green_in <= nxt.green;
                    blue_in  <= nxt.blue;
                    if (nxt.drain && results_due.size() != 0)
                    begin
                        start <= 1'b0;
                    end
                    else
                    begin
                        start <= ($urandom_range(0, 99) >= int'(nxt.idle_pct));
                    end
                end
                else
                begin
                    start <= 1'b0;
                end
            end
            if (moved)
            begin
                stall_cycles = 0;
            end
            else
            begin
                stall_cycles++;
            end
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("%0t timeout with %0d words due", $time, results_due.size());
                $display("FAIL palette_fade_engine_core");
                $finish;
            end
        end
    end

    initial
    begin
        for (int i = 0; i < PALETTE_ENTRIES; i++)
        begin
            cur_shadow[i] = '0;
            tgt_shadow[i] = '0;
        end
        build_stimulus();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        while (!(word_ptr == fade_words.size() && results_due.size() == 0))
        begin
            @(posedge clk);
        end
        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0)
        begin
            $display("PASS palette_fade_engine_core");
        end
        else
        begin
            $display("FAIL palette_fade_engine_core");
        end
        $finish;
    end

endmodule
